// File: hdl/twhsm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package twhsm_pkg;

    // Field widths
    localparam int PHASE_W = 5;
    localparam int BIT_W   = 4;
    localparam int BYTE_W  = 2;
    localparam int TICK_W  = 16;
    localparam int ERR_W   = 2;

    // Sequencer phase codes
    localparam logic [PHASE_W-1:0] PH_IDLE    = 5'd0;
    localparam logic [PHASE_W-1:0] PH_RST_HI  = 5'd1;
    localparam logic [PHASE_W-1:0] PH_RST_LO  = 5'd2;
    localparam logic [PHASE_W-1:0] PH_TS_PREP = 5'd3;
    localparam logic [PHASE_W-1:0] PH_TS_A    = 5'd4;
    localparam logic [PHASE_W-1:0] PH_TS_B    = 5'd5;
    localparam logic [PHASE_W-1:0] PH_TS_C    = 5'd6;
    localparam logic [PHASE_W-1:0] PH_TS_D    = 5'd7;
    localparam logic [PHASE_W-1:0] PH_TS_E    = 5'd8;
    localparam logic [PHASE_W-1:0] PH_TS_F    = 5'd9;
    localparam logic [PHASE_W-1:0] PH_CMD_LO  = 5'd10;
    localparam logic [PHASE_W-1:0] PH_CMD_HI  = 5'd11;
    localparam logic [PHASE_W-1:0] PH_ACK_LO  = 5'd12;
    localparam logic [PHASE_W-1:0] PH_ACK_HI  = 5'd13;
    localparam logic [PHASE_W-1:0] PH_WAIT    = 5'd14;
    localparam logic [PHASE_W-1:0] PH_RD_LO   = 5'd15;
    localparam logic [PHASE_W-1:0] PH_RD_HI   = 5'd16;
    localparam logic [PHASE_W-1:0] PH_RA_LO   = 5'd17;
    localparam logic [PHASE_W-1:0] PH_RA_HI   = 5'd18;

    // Operation modes
    localparam logic [1:0] MODE_TEMP  = 2'd0;
    localparam logic [1:0] MODE_HUMID = 2'd1;
    localparam logic [1:0] MODE_RESET = 2'd2;
    localparam logic [1:0] MODE_NONE  = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] REG_PHASE_TICKS = 2'd0;
    localparam logic [1:0] REG_WAIT_LIMIT  = 2'd1;
    localparam logic [1:0] REG_TEMP_CMD    = 2'd2;
    localparam logic [1:0] REG_HUMID_CMD   = 2'd3;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Register reset values
    localparam logic [7:0]  RST_PHASE_TICKS = 8'd3;
    localparam logic [15:0] RST_WAIT_LIMIT  = 16'hFFFF;
    localparam logic [7:0]  RST_TEMP_CMD    = 8'd3;
    localparam logic [7:0]  RST_HUMID_CMD   = 8'd5;

    typedef struct packed {
        logic [7:0]  phase_ticks;
        logic [15:0] wait_limit;
        logic [7:0]  temperature_command;
        logic [7:0]  humidity_command;
    } t_cfg;

    typedef struct packed {
        logic       start_req;
        logic [1:0] mode;
        logic       data_in;
    } t_tick;

    typedef struct packed {
        logic [ERR_W-1:0] error_count;
        logic [7:0]       check_byte;
        logic [15:0]      reading;
        logic             done_res;
        logic             busy_res;
        logic             data_release;
        logic             sck;
    } t_res;

    localparam int RES_W = $bits(t_res);

endpackage

`default_nettype wire

// File: hdl/two_wire_humidity_sensor_master.sv
`timescale 1ns / 1ps
`default_nettype none

// A tick accepted at one clock edge shows its result on the master side from the
// next cycle, held in the output register until taken. Throughput: one tick per
// cycle while no result waits untaken; the sequencer state and the output register
// both advance in the accepting cycle, so back-to-back ticks need no gaps.
// Reset: synchronous, active low; sequencer idle, registers at their reset values.
module two_wire_humidity_sensor_master #(
    parameter int RESET_PULSES = 9
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration write port
    input  wire logic        i_cfg_wr_en,
    input  wire logic [1:0]  i_cfg_addr,
    input  wire logic [15:0] i_cfg_wdata,
    // tick stream
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [0] start_req, [1] data_in, [7:2] zero
    input  wire logic [1:0]  i_s_tuser,   // [1:0] mode
    // result stream
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [31:0]      o_m_tdata    // [0] sck, [1] data_release, [2] busy_res,
                                          // [3] done_res, [19:4] reading,
                                          // [27:20] check_byte, [29:28] error_count,
                                          // [31:30] zero
);

    twhsm_pkg::t_cfg  w_cfg;
    twhsm_pkg::t_tick w_tick;
    twhsm_pkg::t_res  w_res;
    twhsm_pkg::t_res  r_out_data;
    logic             r_out_valid;
    logic             w_accept;

    twhsm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    assign w_tick.start_req = i_s_tdata[0];
    assign w_tick.data_in   = i_s_tdata[1];
    assign w_tick.mode      = i_s_tuser;

    // Accept while the output register is empty or being emptied
    assign o_s_tready = !r_out_valid || i_m_tready;
    assign w_accept   = i_s_tvalid && o_s_tready;

    twhsm_seq #(
        .RESET_PULSES (RESET_PULSES)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_accept),
        .i_tick  (w_tick),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_data <= w_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {2'b00, r_out_data};

    // Checks
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data.done_res) |-> r_out_data.busy_res)
        else $error("done without busy");

    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_data.done_res) |->
        (r_out_data.reading == 16'd0 && r_out_data.check_byte == 8'd0 &&
         r_out_data.error_count == 2'd0))
        else $error("result fields set outside a completion");

    a_err_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_data.error_count != 2'd3))
        else $error("error count out of range");

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_out_valid)
        else $error("accepted tick produced no result");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_tready) |-> !w_accept)
        else $error("tick accepted over a waiting result");

endmodule

`default_nettype wire

// File: hdl/twhsm_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module twhsm_cfg (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_wr_en,
    input  wire logic [twhsm_pkg::CFG_IDX_W-1:0]    i_cfg_addr,
    input  wire logic [twhsm_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    output twhsm_pkg::t_cfg                         o_cfg
);

    twhsm_pkg::t_cfg r_cfg;

    // Register file, written one register per transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.phase_ticks         <= twhsm_pkg::RST_PHASE_TICKS;
            r_cfg.wait_limit          <= twhsm_pkg::RST_WAIT_LIMIT;
            r_cfg.temperature_command <= twhsm_pkg::RST_TEMP_CMD;
            r_cfg.humidity_command    <= twhsm_pkg::RST_HUMID_CMD;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                twhsm_pkg::REG_PHASE_TICKS: r_cfg.phase_ticks <= i_cfg_wdata[7:0];
                twhsm_pkg::REG_WAIT_LIMIT:  r_cfg.wait_limit  <= i_cfg_wdata;
                twhsm_pkg::REG_TEMP_CMD:    r_cfg.temperature_command <= i_cfg_wdata[7:0];
                twhsm_pkg::REG_HUMID_CMD:   r_cfg.humidity_command    <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// File: hdl/twhsm_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module twhsm_seq #(
    parameter int RESET_PULSES = 9
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_step,
    input  wire twhsm_pkg::t_tick i_tick,
    input  wire twhsm_pkg::t_cfg  i_cfg,
    output twhsm_pkg::t_res  o_res
);

    localparam int BIT_W = twhsm_pkg::BIT_W;
    localparam logic [BIT_W:0] PULSES = (BIT_W+1)'(RESET_PULSES);

    logic [twhsm_pkg::PHASE_W-1:0] r_phase, n_phase;
    logic [BIT_W-1:0]              r_bit_count, n_bit_count;
    logic [twhsm_pkg::BYTE_W-1:0]  r_byte_count, n_byte_count;
    logic [twhsm_pkg::TICK_W-1:0]  r_tick_count, n_tick_count;
    logic [7:0]                    r_shift, n_shift;
    logic [15:0]                   r_value, n_value;
    logic [7:0]                    r_check, n_check;
    logic [twhsm_pkg::ERR_W-1:0]   r_errors, n_errors;
    logic [1:0]                    r_op_mode, n_op_mode;

    logic [twhsm_pkg::PHASE_W-1:0] v_phase;
    logic [7:0]                    v_ptk;
    logic [15:0]                   v_wl;
    logic                          v_last;
    logic                          v_wait_over;
    logic                          v_sck, v_rel, v_done;

    // Next state and tick outputs
    always_comb begin
        n_phase      = r_phase;
        n_bit_count  = r_bit_count;
        n_byte_count = r_byte_count;
        n_tick_count = r_tick_count;
        n_shift      = r_shift;
        n_value      = r_value;
        n_check      = r_check;
        n_errors     = r_errors;
        n_op_mode    = r_op_mode;
        v_sck        = 1'b0;
        v_rel        = 1'b1;
        v_done       = 1'b0;

        v_ptk = (i_cfg.phase_ticks == 8'd0) ? 8'd1 : i_cfg.phase_ticks;
        v_wl  = (i_cfg.wait_limit == 16'd0) ? 16'd1 : i_cfg.wait_limit;

        // unused codes fall back to idle
        v_phase = (r_phase > twhsm_pkg::PH_RA_HI) ? twhsm_pkg::PH_IDLE : r_phase;

        // start of a new operation
        if (v_phase == twhsm_pkg::PH_IDLE && i_tick.start_req &&
            i_tick.mode != twhsm_pkg::MODE_NONE) begin
            n_op_mode    = i_tick.mode;
            n_errors     = '0;
            n_value      = '0;
            n_check      = '0;
            n_bit_count  = '0;
            n_byte_count = '0;
            n_tick_count = '0;
            n_shift      = '0;
            v_phase = (i_tick.mode == twhsm_pkg::MODE_RESET) ? twhsm_pkg::PH_RST_HI
                                                             : twhsm_pkg::PH_TS_PREP;
        end

        // pin levels for this tick
        unique case (v_phase)
            twhsm_pkg::PH_RST_HI:  begin v_sck = 1'b1; v_rel = 1'b1; end
            twhsm_pkg::PH_TS_A:    begin v_sck = 1'b1; v_rel = 1'b1; end
            twhsm_pkg::PH_TS_B:    begin v_sck = 1'b1; v_rel = 1'b0; end
            twhsm_pkg::PH_TS_C:    begin v_sck = 1'b0; v_rel = 1'b0; end
            twhsm_pkg::PH_TS_D:    begin v_sck = 1'b1; v_rel = 1'b0; end
            twhsm_pkg::PH_TS_E:    begin v_sck = 1'b1; v_rel = 1'b1; end
            twhsm_pkg::PH_CMD_LO:  begin v_sck = 1'b0; v_rel = n_shift[7]; end
            twhsm_pkg::PH_CMD_HI:  begin v_sck = 1'b1; v_rel = n_shift[7]; end
            twhsm_pkg::PH_ACK_HI:  begin v_sck = 1'b1; v_rel = 1'b1; end
            twhsm_pkg::PH_RD_HI:   begin v_sck = 1'b1; v_rel = 1'b1; end
            twhsm_pkg::PH_RA_LO:   begin v_sck = 1'b0; v_rel = (n_byte_count >= 2'd2); end
            twhsm_pkg::PH_RA_HI:   begin v_sck = 1'b1; v_rel = (n_byte_count >= 2'd2); end
            default:               begin v_sck = 1'b0; v_rel = 1'b1; end
        endcase

        v_last      = ({1'b0, n_tick_count} + 17'd1) >= {9'd0, v_ptk};
        v_wait_over = ({1'b0, n_tick_count} + 17'd1) >= {1'b0, v_wl};
        n_phase     = v_phase;

        // phase advance
        if (v_phase == twhsm_pkg::PH_WAIT) begin
            if (!i_tick.data_in) begin
                n_tick_count = '0;
                n_bit_count  = '0;
                n_phase      = twhsm_pkg::PH_RD_LO;
            end else if (v_wait_over) begin
                if (n_errors < 2'd2) n_errors = n_errors + 2'd1;
                n_tick_count = '0;
                n_bit_count  = '0;
                n_phase      = twhsm_pkg::PH_RD_LO;
            end else begin
                n_tick_count = n_tick_count + 16'd1;
            end
        end else if (v_phase != twhsm_pkg::PH_IDLE) begin
            if (!v_last) begin
                n_tick_count = n_tick_count + 16'd1;
            end else begin
                n_tick_count = '0;
                unique case (v_phase)
                    twhsm_pkg::PH_RST_HI: n_phase = twhsm_pkg::PH_RST_LO;
                    twhsm_pkg::PH_RST_LO: begin
                        if (({1'b0, n_bit_count} + 1'b1) >= PULSES) begin
                            n_bit_count = '0;
                            n_phase     = twhsm_pkg::PH_TS_PREP;
                        end else begin
                            n_bit_count = n_bit_count + 1'b1;
                            n_phase     = twhsm_pkg::PH_RST_HI;
                        end
                    end
                    twhsm_pkg::PH_TS_F: begin
                        if (n_op_mode == twhsm_pkg::MODE_RESET) begin
                            v_done  = 1'b1;
                            n_phase = twhsm_pkg::PH_IDLE;
                        end else begin
                            n_shift = (n_op_mode == twhsm_pkg::MODE_TEMP)
                                      ? i_cfg.temperature_command
                                      : i_cfg.humidity_command;
                            n_bit_count = '0;
                            n_phase     = twhsm_pkg::PH_CMD_LO;
                        end
                    end
                    twhsm_pkg::PH_CMD_LO: n_phase = twhsm_pkg::PH_CMD_HI;
                    twhsm_pkg::PH_CMD_HI: begin
                        n_shift = {n_shift[6:0], 1'b0};
                        if (n_bit_count >= 4'd7) begin
                            n_bit_count = '0;
                            n_phase     = twhsm_pkg::PH_ACK_LO;
                        end else begin
                            n_bit_count = n_bit_count + 1'b1;
                            n_phase     = twhsm_pkg::PH_CMD_LO;
                        end
                    end
                    twhsm_pkg::PH_ACK_LO: n_phase = twhsm_pkg::PH_ACK_HI;
                    twhsm_pkg::PH_ACK_HI: begin
                        // no acknowledge from the sensor
                        if (i_tick.data_in && n_errors < 2'd2) n_errors = n_errors + 2'd1;
                        n_phase = twhsm_pkg::PH_WAIT;
                    end
                    twhsm_pkg::PH_RD_LO: n_phase = twhsm_pkg::PH_RD_HI;
                    twhsm_pkg::PH_RD_HI: begin
                        n_shift = {n_shift[6:0], i_tick.data_in};
                        if (n_bit_count >= 4'd7) begin
                            n_bit_count = '0;
                            n_phase     = twhsm_pkg::PH_RA_LO;
                        end else begin
                            n_bit_count = n_bit_count + 1'b1;
                            n_phase     = twhsm_pkg::PH_RD_LO;
                        end
                    end
                    twhsm_pkg::PH_RA_LO: n_phase = twhsm_pkg::PH_RA_HI;
                    twhsm_pkg::PH_RA_HI: begin
                        if (n_byte_count == 2'd0)      n_value = {n_shift, 8'h00};
                        else if (n_byte_count == 2'd1) n_value = {n_value[15:8], n_shift};
                        else                           n_check = n_shift;
                        if (n_byte_count >= 2'd2) begin
                            v_done  = 1'b1;
                            n_phase = twhsm_pkg::PH_IDLE;
                        end else begin
                            n_byte_count = n_byte_count + 2'd1;
                            n_phase      = twhsm_pkg::PH_RD_LO;
                        end
                    end
                    // the fixed start pattern steps straight through
                    default: n_phase = v_phase + 5'd1;
                endcase
            end
        end

        o_res.sck          = v_sck;
        o_res.data_release = v_rel;
        o_res.busy_res     = (v_phase != twhsm_pkg::PH_IDLE);
        o_res.done_res     = v_done;
        o_res.reading      = v_done ? n_value  : 16'd0;
        o_res.check_byte   = v_done ? n_check  : 8'd0;
        o_res.error_count  = v_done ? n_errors : 2'd0;
    end

    // Sequencer state, advanced once per accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= twhsm_pkg::PH_IDLE;
            r_bit_count  <= '0;
            r_byte_count <= '0;
            r_tick_count <= '0;
            r_shift      <= '0;
            r_value      <= '0;
            r_check      <= '0;
            r_errors     <= '0;
            r_op_mode    <= '0;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_bit_count  <= n_bit_count;
            r_byte_count <= n_byte_count;
            r_tick_count <= n_tick_count;
            r_shift      <= n_shift;
            r_value      <= n_value;
            r_check      <= n_check;
            r_errors     <= n_errors;
            r_op_mode    <= n_op_mode;
        end
    end

endmodule

`default_nettype wire
